>>> sv/hsv_depth_color_key_filter_defines.svh
// Assertion macros shared by the HSV depth color key filter RTL.
`ifndef HSV_DEPTH_COLOR_KEY_FILTER_DEFINES_SVH
`define HSV_DEPTH_COLOR_KEY_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define HSVK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsvk: same-cycle check failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define HSVK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsvk: next-cycle check failed");

`endif

>>> sv/hsvk_pkg.sv
// Types, constants and register codes of the HSV depth color key filter.
package hsvk_pkg;

    // Divider cell chain: one quotient bit per cell.
    localparam int DIV_STEPS = 11;
    localparam int Q_W       = DIV_STEPS;
    localparam int DSH_W     = 8 + DIV_STEPS - 1;
    localparam int REM_W     = DSH_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [11:0] HUE_FULL   = 12'd3600;
    localparam logic [11:0] HUE_OFF_R  = 12'd0;
    localparam logic [11:0] HUE_OFF_G  = 12'd1200;
    localparam logic [11:0] HUE_OFF_B  = 12'd2400;
    localparam logic [12:0] HUE_BIAS   = 13'd3000;
    localparam logic [9:0]  HUE_SIXTH  = 10'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_LIMIT     = 3'd0,
        CFG_TARGET_HUE      = 3'd1,
        CFG_HUE_TOLERANCE   = 3'd2,
        CFG_SATURATION_LOW  = 3'd3,
        CFG_SATURATION_HIGH = 3'd4,
        CFG_BRIGHTNESS_LOW  = 3'd5,
        CFG_BRIGHTNESS_HIGH = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [31:0] depth;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic               keep;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic signed [31:0] out_depth;
        logic               out_last;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] depth_limit;
        logic [11:0]        target_hue;
        logic [10:0]        hue_tolerance;
        logic [7:0]         saturation_low;
        logic [7:0]         saturation_high;
        logic [7:0]         brightness_low;
        logic [7:0]         brightness_high;
    } t_cfg;

    // Data that rides along the divider chain untouched.
    typedef struct packed {
        t_in_item    item;
        logic [7:0]  value;
        logic [11:0] hue_off;
        logic        hue_zero;
        logic        sat_zero;
    } t_side;

    // One restoring division lane: partial remainder, shifted divisor, quotient.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DSH_W-1:0] dsh;
        logic [Q_W-1:0]   quo;
    } t_lane;

    typedef struct packed {
        t_side side;
        t_lane hue;
        t_lane sat;
    } t_cell_data;

endpackage

>>> sv/hsvk_front.sv
// Input stage: max, min, hue sector and divider operands for one point.
module hsvk_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hsvk_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hsvk_pkg::t_cell_data  o_data
);
    import hsvk_pkg::*;

    logic        r_valid;
    t_cell_data  r_data;
    t_cell_data  n_data;
    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  d;
    logic [9:0]  t_sum;
    logic [11:0] hue_off;
    logic [18:0] num;
    logic [15:0] sat_dvd;

    always_comb begin
        mx = i_item.red;
        mn = i_item.red;
        if (i_item.green > mx) mx = i_item.green;
        if (i_item.blue > mx) mx = i_item.blue;
        if (i_item.green < mn) mn = i_item.green;
        if (i_item.blue < mn) mn = i_item.blue;
        d = mx - mn;

        // The signed difference plus d is never negative, so the quotient is a floor.
        if (mx == i_item.red) begin
            t_sum   = {2'b00, i_item.green} - {2'b00, i_item.blue} + {2'b00, d};
            hue_off = HUE_OFF_R;
        end else if (mx == i_item.green) begin
            t_sum   = {2'b00, i_item.blue} - {2'b00, i_item.red} + {2'b00, d};
            hue_off = HUE_OFF_G;
        end else begin
            t_sum   = {2'b00, i_item.red} - {2'b00, i_item.green} + {2'b00, d};
            hue_off = HUE_OFF_B;
        end

        num     = {10'b0, t_sum[8:0]} * {9'b0, HUE_SIXTH};
        sat_dvd = {d, 8'b0} - {8'b0, d};

        n_data.side.item     = i_item;
        n_data.side.value    = mx;
        n_data.side.hue_off  = hue_off;
        n_data.side.hue_zero = (d == 8'd0);
        n_data.side.sat_zero = (mx == 8'd0);
        n_data.hue.rem       = REM_W'(num);
        n_data.hue.dsh       = {d, {(Q_W-1){1'b0}}};
        n_data.hue.quo       = '0;
        n_data.sat.rem       = REM_W'(sat_dvd);
        n_data.sat.dsh       = {mx, {(Q_W-1){1'b0}}};
        n_data.sat.quo       = '0;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sv/hsvk_cell.sv
// One divider cell: a restoring step on the hue and saturation lanes.
module hsvk_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hsvk_pkg::t_cell_data  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hsvk_pkg::t_cell_data  o_data
);
    import hsvk_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    function automatic t_lane lane_step(input t_lane a);
        t_lane s;
        s.dsh = a.dsh >> 1;
        if (a.rem >= {1'b0, a.dsh}) begin
            s.rem = a.rem - {1'b0, a.dsh};
            s.quo = {a.quo[Q_W-2:0], 1'b1};
        end else begin
            s.rem = a.rem;
            s.quo = {a.quo[Q_W-2:0], 1'b0};
        end
        return s;
    endfunction

    always_comb begin
        n_data.side = i_data.side;
        n_data.hue  = lane_step(i_data.hue);
        n_data.sat  = lane_step(i_data.sat);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sv/hsvk_back.sv
// Output stages: hue and saturation finish, then threshold tests and result register.
module hsvk_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsvk_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hsvk_pkg::t_cell_data  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hsvk_pkg::t_out_item   o_item
);
    import hsvk_pkg::*;

    logic        r_valid_a;
    t_in_item    r_item_a;
    logic [7:0]  r_value_a;
    logic [11:0] r_hue_a;
    logic [7:0]  r_sat_a;
    logic [12:0] hue_sum;
    logic [11:0] n_hue_a;
    logic [7:0]  n_sat_a;
    logic        ready_a;

    logic        r_valid_b;
    t_out_item   r_item_b;
    t_out_item   n_item_b;
    logic [11:0] tgt;
    logic [11:0] e;
    logic [11:0] alt;
    logic [11:0] hue_gap;
    logic        ready_b;

    // Stage A: remove the floor bias, wrap into one turn, clear degenerate cases.
    always_comb begin
        hue_sum = {2'b00, i_data.hue.quo} + {1'b0, i_data.side.hue_off} + HUE_BIAS;
        if (hue_sum >= {1'b0, HUE_FULL}) begin
            hue_sum = hue_sum - {1'b0, HUE_FULL};
        end
        n_hue_a = i_data.side.hue_zero ? 12'd0 : hue_sum[11:0];
        n_sat_a = i_data.side.sat_zero ? 8'd0 : i_data.sat.quo[7:0];
    end

    assign ready_a = !r_valid_a || ready_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else if (ready_a) begin
            r_valid_a <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_item_a  <= i_data.side.item;
            r_value_a <= i_data.side.value;
            r_hue_a   <= n_hue_a;
            r_sat_a   <= n_sat_a;
        end
    end

    // Stage B: circular hue distance and all strict threshold tests.
    always_comb begin
        tgt     = (i_cfg.target_hue >= HUE_FULL) ? i_cfg.target_hue - HUE_FULL
                                                 : i_cfg.target_hue;
        e       = (r_hue_a >= tgt) ? r_hue_a - tgt : tgt - r_hue_a;
        alt     = HUE_FULL - e;
        hue_gap = (alt < e) ? alt : e;

        n_item_b.keep      = ($signed(r_item_a.depth) < $signed(i_cfg.depth_limit))
                          && (hue_gap < {1'b0, i_cfg.hue_tolerance})
                          && (r_sat_a > i_cfg.saturation_low)
                          && (r_sat_a < i_cfg.saturation_high)
                          && (r_value_a > i_cfg.brightness_low)
                          && (r_value_a < i_cfg.brightness_high);
        n_item_b.out_red   = r_item_a.red;
        n_item_b.out_green = r_item_a.green;
        n_item_b.out_blue  = r_item_a.blue;
        n_item_b.out_depth = r_item_a.depth;
        n_item_b.out_last  = r_item_a.last_point;
    end

    assign ready_b = !r_valid_b || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
        end else if (ready_b) begin
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_valid_a) begin
            r_item_b <= n_item_b;
        end
    end

    assign o_ready = ready_a;
    assign o_valid = r_valid_b;
    assign o_item  = r_item_b;

endmodule

>>> sv/hsv_depth_color_key_filter.sv
// Top level of the HSV depth color key filter: config registers and the cell chain.
//
// Usage: each item on the input channel (i_valid, o_ready, i_item) is one colored
// point: 8-bit red, green and blue, a Q16.16 depth and a last-point mark. For every
// accepted item exactly one item leaves on the output channel (o_valid, i_ready,
// o_item) in the same order, carrying a keep flag and the point passed through.
// The point is kept when its depth is below the depth limit, its circular hue
// distance to the target hue is below the tolerance, and its saturation and value
// lie strictly between their limits.
// From acceptance to o_valid an item passes one front stage, eleven divider
// cells (one quotient bit of hue and of saturation per cell) and two output stages.
// Throughput is one item per cycle while i_ready is high; every stage is a
// register with its own valid bit, so bubbles close up and a new item is taken
// while a result waits.
// When the receiver holds i_ready low, the result stays on o_item and stages fill
// behind it; o_ready drops only once every stage holds an item.
// Synchronous reset empties the pipeline and loads the default thresholds.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data while no
// item is in flight; indexes beyond the last register are ignored.
`include "hsv_depth_color_key_filter_defines.svh"

module hsv_depth_color_key_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hsvk_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hsvk_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  hsvk_pkg::t_in_item                  i_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output hsvk_pkg::t_out_item                 o_item
);
    import hsvk_pkg::*;

    t_cfg       r_cfg;
    logic       c_valid [DIV_STEPS+1];
    logic       c_ready [DIV_STEPS+1];
    t_cell_data c_data  [DIV_STEPS+1];

    // Register file. Each register keeps only the bits it is declared with.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_limit     <= 32'sd5898240;
            r_cfg.target_hue      <= 12'd0;
            r_cfg.hue_tolerance   <= 11'd200;
            r_cfg.saturation_low  <= 8'd77;
            r_cfg.saturation_high <= 8'd255;
            r_cfg.brightness_low  <= 8'd77;
            r_cfg.brightness_high <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DEPTH_LIMIT:     r_cfg.depth_limit     <= i_cfg_data;
                CFG_TARGET_HUE:      r_cfg.target_hue      <= i_cfg_data[11:0];
                CFG_HUE_TOLERANCE:   r_cfg.hue_tolerance   <= i_cfg_data[10:0];
                CFG_SATURATION_LOW:  r_cfg.saturation_low  <= i_cfg_data[7:0];
                CFG_SATURATION_HIGH: r_cfg.saturation_high <= i_cfg_data[7:0];
                CFG_BRIGHTNESS_LOW:  r_cfg.brightness_low  <= i_cfg_data[7:0];
                CFG_BRIGHTNESS_HIGH: r_cfg.brightness_high <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Front stage finds max, min and the hue sector and loads both divider lanes.
    hsvk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_data  (c_data[0])
    );

    // Row of identical divider cells; each hands its item to the next one.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        hsvk_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_data  (c_data[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_data  (c_data[k+1])
        );
    end

    // Hue wrap, saturation clean-up, threshold tests and the result register.
    hsvk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (c_valid[DIV_STEPS]),
        .o_ready (c_ready[DIV_STEPS]),
        .i_data  (c_data[DIV_STEPS]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // An accepted item always lands in the front stage.
    `HSVK_ASSERT_NXT(a_accept_loads_front, i_valid && o_ready, c_valid[0])
    // The input side can only be blocked when a result is waiting at the output.
    `HSVK_ASSERT_IMP(a_stall_needs_result, !o_ready, o_valid)
    // A kept point has nonzero saturation, so it cannot be gray.
    `HSVK_ASSERT_IMP(a_keep_not_gray, o_valid && o_item.keep,
        (o_item.out_red != o_item.out_green) || (o_item.out_green != o_item.out_blue))
    // A kept point has a value strictly below full scale in every component.
    `HSVK_ASSERT_IMP(a_keep_not_full, o_valid && o_item.keep,
        (o_item.out_red != 8'hFF) && (o_item.out_green != 8'hFF)
        && (o_item.out_blue != 8'hFF))

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the HSV depth color key filter.
`timescale 1ns / 1ps

module tb;
    import hsvk_pkg::*;

    // The run is stopped here if results stop coming; this is several times the
    // slowest correct run of about 2000 items with the longest gaps and stalls.
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 20;

    // Idle patterns for either side of the block.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_FULL = 1;
    localparam int IDLE_SPARSE = 2;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    t_in_item               i_item = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    t_out_item              o_item;

    // Thresholds as the block should currently hold them.
    t_cfg                   key_cfg;

    // Points waiting to be sent, and the results that accepted points must give.
    t_in_item               point_q[$];
    t_out_item              filtered_q[$];
    t_out_item              want_result;

    int send_mode = IDLE_NONE;
    int recv_mode = IDLE_NONE;
    int send_wait = 0;
    int stall_wait = 0;
    bit hold_sender = 1'b0;

    int points_sent = 0;
    int results_checked = 0;
    int kept_count = 0;
    int settings_count = 0;
    int fail_count = 0;
    int cycle_count = 0;

    hsv_depth_color_key_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Computes the keep decision for one point under the current thresholds.
    // Hue is worked out in tenths of a degree; the numerator is biased by one
    // sixth of the circle so that the division always rounds toward minus
    // infinity, and the bias is taken back out before the wrap to 0..3599.
    function automatic t_out_item filter_point(t_in_item p);
        int r, g, b, mx, mn, d, diff, off, hue, sat, tgt, e, hue_gap;
        t_out_item res;
        r = p.red;
        g = p.green;
        b = p.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sat = (mx == 0) ? 0 : (d * 255) / mx;
        if (d == 0) begin
            hue = 0;
        end else begin
            if (mx == r) begin
                diff = g - b;
                off = 0;
            end else if (mx == g) begin
                diff = b - r;
                off = 1200;
            end else begin
                diff = r - g;
                off = 2400;
            end
            hue = ((600 * diff + 600 * d) / d + off + 3000) % 3600;
        end
        // A target beyond the circle is folded back once.
        tgt = key_cfg.target_hue;
        if (tgt >= 3600) tgt = tgt - 3600;
        e = (hue >= tgt) ? hue - tgt : tgt - hue;
        hue_gap = (3600 - e < e) ? 3600 - e : e;
        res.keep = ($signed(p.depth) < $signed(key_cfg.depth_limit))
            && (hue_gap < int'(key_cfg.hue_tolerance))
            && (sat > int'(key_cfg.saturation_low))
            && (sat < int'(key_cfg.saturation_high))
            && (mx > int'(key_cfg.brightness_low))
            && (mx < int'(key_cfg.brightness_high));
        res.out_red = p.red;
        res.out_green = p.green;
        res.out_blue = p.blue;
        res.out_depth = p.depth;
        res.out_last = p.last_point;
        return res;
    endfunction

    // Number of idle cycles a side spends before its next item.
    function automatic int draw_wait(int mode);
        if (mode == IDLE_FULL) return $urandom_range(0, 16);
        if (mode == IDLE_SPARSE) return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        return 0;
    endfunction

    // Draws a point. Most points are searched for among random colors so that
    // they pass the current key and exercise the full decision path; the rest
    // are plain random, grey or built from extreme component values.
    function automatic t_in_item random_point();
        t_in_item p;
        t_out_item trial;
        logic [7:0] corner[4];
        int kind, tries;
        corner = '{8'd0, 8'd1, 8'd254, 8'd255};
        case ($urandom_range(0, 3))
            0: p.depth = $urandom;
            1: p.depth = key_cfg.depth_limit + $urandom_range(0, 4) - 2;
            2: p.depth = corner[$urandom_range(0, 3)] == 8'd0 ? 32'sh80000000 :
                         ($urandom_range(0, 1) ? 32'sh7FFFFFFF : -32'sd1);
            default: p.depth = key_cfg.depth_limit - $urandom_range(1, 65536);
        endcase
        p.last_point = ($urandom_range(0, 7) == 0);
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                p.red = $urandom;
                p.green = $urandom;
                p.blue = $urandom;
            end
            2: begin
                p.red = $urandom;
                p.green = p.red;
                p.blue = p.red;
            end
            3: begin
                p.red = corner[$urandom_range(0, 3)];
                p.green = corner[$urandom_range(0, 3)];
                p.blue = corner[$urandom_range(0, 3)];
            end
            default: begin
                if ($urandom_range(0, 3) != 0 && key_cfg.depth_limit != 32'sh80000000)
                    p.depth = key_cfg.depth_limit - $urandom_range(1, 65536);
                for (tries = 0; tries < 64; tries++) begin
                    p.red = $urandom;
                    p.green = $urandom;
                    p.blue = $urandom;
                    trial = filter_point(p);
                    if (trial.keep) break;
                end
            end
        endcase
        return p;
    endfunction

    // Random thresholds, mostly wide enough that points pass, now and then
    // with the target folded, a zero or oversized tolerance, or inverted limits.
    function automatic t_cfg random_thresholds();
        t_cfg c;
        c.depth_limit = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200 << 16);
        c.target_hue = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 3599);
        case ($urandom_range(0, 7))
            0: c.hue_tolerance = 0;
            1: c.hue_tolerance = $urandom_range(1801, 2047);
            default: c.hue_tolerance = $urandom_range(1, 1800);
        endcase
        c.saturation_low = $urandom_range(0, 150);
        c.saturation_high = $urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                      : $urandom_range(c.saturation_low, 255);
        c.brightness_low = $urandom_range(0, 150);
        c.brightness_high = $urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                      : $urandom_range(c.brightness_low, 255);
        return c;
    endfunction

    // One register write; the write enable stays high for a single edge.
    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_thresholds(t_cfg c);
        write_reg(CFG_DEPTH_LIMIT, c.depth_limit);
        write_reg(CFG_TARGET_HUE, 32'(c.target_hue));
        write_reg(CFG_HUE_TOLERANCE, 32'(c.hue_tolerance));
        write_reg(CFG_SATURATION_LOW, 32'(c.saturation_low));
        write_reg(CFG_SATURATION_HIGH, 32'(c.saturation_high));
        write_reg(CFG_BRIGHTNESS_LOW, 32'(c.brightness_low));
        write_reg(CFG_BRIGHTNESS_HIGH, 32'(c.brightness_high));
        key_cfg = c;
        settings_count++;
    endtask

    task automatic add_point(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [31:0] depth, logic last_point);
        t_in_item p;
        p.red = r;
        p.green = g;
        p.blue = b;
        p.depth = depth;
        p.last_point = last_point;
        point_q.insert(point_q.size(), p);
    endtask

    // Waits until every queued point has been sent and every result has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        while (point_q.size() != 0 || i_valid || filtered_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Sends one batch of random points under the current thresholds. Halfway
    // through, the sender is held until the block has emptied completely.
    task automatic run_batch(int count);
        int k;
        send_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
        recv_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
        for (k = 0; k < count; k++)
            point_q.insert(point_q.size(), random_point());
        @(negedge i_clk);
        while (point_q.size() > count / 2)
            @(negedge i_clk);
        hold_sender = 1'b1;
        while (i_valid || filtered_q.size() != 0)
            @(negedge i_clk);
        hold_sender = 1'b0;
        wait_idle();
    endtask

    // Driver: presents queued points and records the expected result of each
    // point at the edge where it is accepted. A presented point is held until
    // it is taken; afterward the sender waits its drawn number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_valid && o_ready) begin
                filtered_q.insert(filtered_q.size(), filter_point(i_item));
                points_sent++;
                send_wait = draw_wait(send_mode);
            end
            if (!i_valid || o_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (point_q.size() != 0 && !hold_sender) begin
                    i_item <= point_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
        fail_count++;
    endtask

    // Monitor: checks each accepted result against the oldest expectation and
    // stalls the result channel for a drawn number of cycles after each item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_wait = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, o_item);
                    fail_count++;
                end else begin
                    want_result = filtered_q.pop_front();
                    results_checked++;
                    if (want_result.keep) kept_count++;
                    if (o_item.keep !== want_result.keep)
                        report_mismatch("keep", 32'(want_result.keep), 32'(o_item.keep));
                    if (o_item.out_red !== want_result.out_red)
                        report_mismatch("out_red", 32'(want_result.out_red),
                                        32'(o_item.out_red));
                    if (o_item.out_green !== want_result.out_green)
                        report_mismatch("out_green", 32'(want_result.out_green),
                                        32'(o_item.out_green));
                    if (o_item.out_blue !== want_result.out_blue)
                        report_mismatch("out_blue", 32'(want_result.out_blue),
                                        32'(o_item.out_blue));
                    if (o_item.out_depth !== want_result.out_depth)
                        report_mismatch("out_depth", want_result.out_depth, o_item.out_depth);
                    if (o_item.out_last !== want_result.out_last)
                        report_mismatch("out_last", 32'(want_result.out_last),
                                        32'(o_item.out_last));
                end
                stall_wait = draw_wait(recv_mode);
            end
            if (stall_wait > 0) begin
                stall_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, filtered_q.size());
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        t_cfg corner_cfg[5];
        int k;

        // Power-on thresholds of the block.
        key_cfg = '{32'sd5898240, 12'd0, 11'd200, 8'd77, 8'd255, 8'd77, 8'd255};

        // Corner settings: everything open with the target at the top of the
        // circle; everything shut with the lowest depth limit and inverted
        // limits; zero tolerance with a folded target; a target of exactly one
        // full circle with the widest tolerance; equal low and high limits.
        corner_cfg[0] = '{32'sh7FFFFFFF, 12'd3599, 11'd1800, 8'd0, 8'd255, 8'd0, 8'd255};
        corner_cfg[1] = '{32'sh80000000, 12'd0, 11'd1, 8'd255, 8'd0, 8'd255, 8'd0};
        corner_cfg[2] = '{32'sd0, 12'd4095, 11'd0, 8'd0, 8'd255, 8'd0, 8'd255};
        corner_cfg[3] = '{32'sh40000000, 12'd3600, 11'd2047, 8'd1, 8'd254, 8'd1, 8'd254};
        corner_cfg[4] = '{32'sd0, 12'd4000, 11'd300, 8'd100, 8'd100, 8'd50, 8'd250};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points under the power-on thresholds, sent back to back.
        add_point(8'd0, 8'd0, 8'd0, 32'd0, 1'b0);                  // black
        add_point(8'd255, 8'd255, 8'd255, 32'd0, 1'b0);            // white
        add_point(8'd128, 8'd128, 8'd128, 32'd100, 1'b0);          // grey
        add_point(8'd255, 8'd0, 8'd0, 32'd0, 1'b0);                // value at the top limit
        add_point(8'd200, 8'd20, 8'd20, 32'd0, 1'b0);              // plain hit
        add_point(8'd200, 8'd20, 8'd40, 32'hFFFF0000, 1'b0);       // hue wraps below zero
        add_point(8'd200, 8'd40, 8'd20, 32'd0, 1'b0);
        add_point(8'd20, 8'd200, 8'd20, 32'd0, 1'b0);              // green sector
        add_point(8'd20, 8'd20, 8'd200, 32'd0, 1'b0);              // blue sector
        add_point(8'd200, 8'd200, 8'd20, 32'd0, 1'b0);             // red ties green
        add_point(8'd20, 8'd200, 8'd200, 32'd0, 1'b0);             // green ties blue
        add_point(8'd200, 8'd20, 8'd200, 32'd0, 1'b0);             // red ties blue
        add_point(8'd200, 8'd20, 8'd20, 32'd5898240, 1'b0);        // depth at the limit
        add_point(8'd200, 8'd20, 8'd20, 32'd5898239, 1'b0);        // depth just below
        add_point(8'd200, 8'd20, 8'd20, 32'h80000000, 1'b1);       // most negative depth
        add_point(8'd200, 8'd20, 8'd20, 32'h7FFFFFFF, 1'b0);       // most positive depth
        add_point(8'd1, 8'd0, 8'd0, 32'd0, 1'b1);
        add_point(8'd90, 8'd20, 8'd20, 32'd0, 1'b0);               // dim but above the limit
        add_point(8'd77, 8'd10, 8'd10, 32'd0, 1'b0);               // value at the low limit
        add_point(8'd78, 8'd0, 8'd0, 32'd0, 1'b0);                 // full saturation
        add_point(8'd255, 8'd0, 8'd255, 32'd0, 1'b0);
        add_point(8'd0, 8'd255, 8'd0, 32'hFFFFFFFF, 1'b1);
        add_point(8'd254, 8'd1, 8'd1, 32'd65536, 1'b0);
        add_point(8'd255, 8'd254, 8'd0, 32'd0, 1'b1);
        wait_idle();

        for (k = 0; k < 5; k++) begin
            apply_thresholds(corner_cfg[k]);
            run_batch(120);
        end
        for (k = 0; k < 7; k++) begin
            apply_thresholds(random_thresholds());
            run_batch(200);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d points under %0d threshold settings after power-on defaults;",
                 points_sent, settings_count);
        $display("checked %0d results, %0d of them kept, with %0d mismatches.",
                 results_checked, kept_count, fail_count);
        if (fail_count == 0 && filtered_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
